[hw/rtl/vcs_pkg.sv]
package vcs_pkg;

    // Configuration register indexes
    localparam int REG_ADDR_W = 3;

    localparam logic [REG_ADDR_W-1:0] REG_LINEAR_COEFF     = 3'd0;
    localparam logic [REG_ADDR_W-1:0] REG_ANGULAR_COEFF    = 3'd1;
    localparam logic [REG_ADDR_W-1:0] REG_LINEAR_LIMIT     = 3'd2;
    localparam logic [REG_ADDR_W-1:0] REG_LINEAR_DEADBAND  = 3'd3;
    localparam logic [REG_ADDR_W-1:0] REG_ANGULAR_LIMIT    = 3'd4;
    localparam logic [REG_ADDR_W-1:0] REG_ANGULAR_DEADBAND = 3'd5;

    // Reset values, Q3.12 magnitudes (1.0, 0.01, PI/2, 0.02)
    localparam int LINEAR_LIMIT_RST     = 4096;
    localparam int LINEAR_DEADBAND_RST  = 41;
    localparam int ANGULAR_LIMIT_RST    = 6434;
    localparam int ANGULAR_DEADBAND_RST = 82;

    // Per-lane control for one accepted transaction
    typedef struct packed {
        logic fire;
        logic clear;
    } lane_ctrl_t;

endpackage

[hw/rtl/vcs_lane.sv]
module vcs_lane
    import vcs_pkg::*;
#(
    parameter int DATA_WIDTH  = 16,
    parameter int COEFF_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lane_ctrl_t                    ctrl,
    input  logic signed [DATA_WIDTH-1:0]  cmd,
    input  logic        [COEFF_WIDTH-1:0] coeff,
    input  logic        [DATA_WIDTH-2:0]  limit,
    input  logic        [DATA_WIDTH-2:0]  deadband,
    output logic signed [DATA_WIDTH-1:0]  result,
    output logic signed [DATA_WIDTH-1:0]  state
);

    localparam int ACC_W = DATA_WIDTH + COEFF_WIDTH + 2;

    logic signed [DATA_WIDTH-1:0]  state_reg;
    logic signed [DATA_WIDTH-1:0]  state_next;
    logic signed [DATA_WIDTH:0]    diff;
    logic signed [COEFF_WIDTH:0]   coeff_s;
    logic signed [ACC_W-1:0]       prod;
    logic signed [ACC_W-1:0]       base;
    logic signed [ACC_W-1:0]       acc;
    logic signed [DATA_WIDTH-1:0]  filt;
    logic        [DATA_WIDTH-1:0]  mag;
    logic signed [DATA_WIDTH-1:0]  lim_pos;
    logic signed [DATA_WIDTH-1:0]  lim_neg;
    logic signed [DATA_WIDTH-1:0]  clamped;
    logic                          in_deadband;

    // a*s + (1-a)*x rewritten as x + a*(s - x): one multiplier per lane
    assign diff    = {state_reg[DATA_WIDTH-1], state_reg} - {cmd[DATA_WIDTH-1], cmd};
    assign coeff_s = {1'b0, coeff};
    assign prod    = coeff_s * diff;
    assign base    = {{(ACC_W-DATA_WIDTH-COEFF_WIDTH){cmd[DATA_WIDTH-1]}}, cmd,
                      {COEFF_WIDTH{1'b0}}};
    assign acc     = base + prod;

    // arithmetic shift floors; the convex combination always fits DATA_WIDTH
    assign filt = acc[COEFF_WIDTH +: DATA_WIDTH];

    assign mag         = filt[DATA_WIDTH-1] ? (~filt + 1'b1) : filt;
    assign in_deadband = mag < {1'b0, deadband};

    assign lim_pos = {1'b0, limit};
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (filt > lim_pos)
        begin
            clamped = lim_pos;
        end
        else if (filt < lim_neg)
        begin
            clamped = lim_neg;
        end
        else
        begin
            clamped = filt;
        end
    end

    always_comb
    begin
        if (ctrl.clear)
        begin
            state_next = '0;
            result     = '0;
        end
        else if (in_deadband)
        begin
            state_next = filt;
            result     = '0;
        end
        else
        begin
            state_next = clamped;
            result     = clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (ctrl.fire)
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

[hw/rtl/vcs_merge.sv]
module vcs_merge
    import vcs_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int TDATA_W    = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic signed [DATA_WIDTH-1:0] linear_res,
    input  logic signed [DATA_WIDTH-1:0] angular_res,
    output logic                         ready,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [TDATA_W-1:0]           m_axis_tdata,
    output logic                         skid_valid
);

    logic               main_valid_reg;
    logic [TDATA_W-1:0] main_data_reg;
    logic               skid_valid_reg;
    logic [TDATA_W-1:0] skid_data_reg;
    logic [TDATA_W-1:0] packed_res;
    logic               pop;

    // linear in the low half, angular above, zero padded to bytes
    assign packed_res = TDATA_W'({angular_res, linear_res});
    assign pop        = main_valid_reg & m_axis_tready;
    assign ready      = ~skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                main_data_reg <= packed_res;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_data_reg <= packed_res;
            end
            else
            begin
                main_data_reg <= packed_res;
            end
        end
    end

    assign m_axis_tvalid = main_valid_reg;
    assign m_axis_tdata  = main_data_reg;
    assign skid_valid    = skid_valid_reg;

endmodule

[hw/rtl/velocity_command_smoother.sv]
// Velocity command smoother: two first-order exponential smoothers, one for
// linear and one for angular speed (Q3.12), each with a deadband and a
// symmetric limit. One transaction in gives one transaction out. A new command
// is taken every clock cycle while the skid entry is empty; results go to the
// output register or the skid entry behind it. The rate is set by each lane's
// state feedback loop: one multiply-add, deadband compare and clamp per cycle.
// A two-entry output buffer keeps input accepting while one result waits
// downstream. Coefficient, limit and deadband registers are written through
// wr_en/wr_addr/wr_data and must only change while the block is idle.
module velocity_command_smoother
    import vcs_pkg::*;
#(
    parameter int DATA_WIDTH  = 16,
    parameter int COEFF_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [DATA_WIDTH-1:0] linear_cmd, [2*DATA_WIDTH-1:DATA_WIDTH] angular_cmd
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // [0] clear
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [DATA_WIDTH-1:0] linear_out, [2*DATA_WIDTH-1:DATA_WIDTH] angular_out
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input  logic                  wr_en,
    input  logic [REG_ADDR_W-1:0] wr_addr,
    input  logic [((COEFF_WIDTH > DATA_WIDTH-1) ? COEFF_WIDTH : DATA_WIDTH-1)-1:0] wr_data
);

    localparam int TDATA_W = ((2*DATA_WIDTH+7)/8)*8;
    localparam int LIM_W   = DATA_WIDTH - 1;

    logic [COEFF_WIDTH-1:0] linear_coeff_reg;
    logic [COEFF_WIDTH-1:0] angular_coeff_reg;
    logic [LIM_W-1:0]       linear_limit_reg;
    logic [LIM_W-1:0]       linear_deadband_reg;
    logic [LIM_W-1:0]       angular_limit_reg;
    logic [LIM_W-1:0]       angular_deadband_reg;

    lane_ctrl_t                   lane_ctrl;
    logic signed [DATA_WIDTH-1:0] linear_cmd;
    logic signed [DATA_WIDTH-1:0] angular_cmd;
    logic signed [DATA_WIDTH-1:0] linear_res;
    logic signed [DATA_WIDTH-1:0] angular_res;
    logic signed [DATA_WIDTH-1:0] linear_state;
    logic signed [DATA_WIDTH-1:0] angular_state;
    logic                         in_fire;
    logic                         skid_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_coeff_reg     <= '0;
            angular_coeff_reg    <= '0;
            linear_limit_reg     <= LIM_W'(LINEAR_LIMIT_RST);
            linear_deadband_reg  <= LIM_W'(LINEAR_DEADBAND_RST);
            angular_limit_reg    <= LIM_W'(ANGULAR_LIMIT_RST);
            angular_deadband_reg <= LIM_W'(ANGULAR_DEADBAND_RST);
        end
        else if (wr_en)
        begin
            case (wr_addr)
                REG_LINEAR_COEFF:     linear_coeff_reg     <= wr_data[COEFF_WIDTH-1:0];
                REG_ANGULAR_COEFF:    angular_coeff_reg    <= wr_data[COEFF_WIDTH-1:0];
                REG_LINEAR_LIMIT:     linear_limit_reg     <= wr_data[LIM_W-1:0];
                REG_LINEAR_DEADBAND:  linear_deadband_reg  <= wr_data[LIM_W-1:0];
                REG_ANGULAR_LIMIT:    angular_limit_reg    <= wr_data[LIM_W-1:0];
                REG_ANGULAR_DEADBAND: angular_deadband_reg <= wr_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_fire         = s_axis_tvalid & s_axis_tready;
    assign lane_ctrl.fire  = in_fire;
    assign lane_ctrl.clear = s_axis_tuser;
    assign linear_cmd      = s_axis_tdata[DATA_WIDTH-1:0];
    assign angular_cmd     = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

    vcs_lane #(
        .DATA_WIDTH  (DATA_WIDTH),
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_linear_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (lane_ctrl),
        .cmd      (linear_cmd),
        .coeff    (linear_coeff_reg),
        .limit    (linear_limit_reg),
        .deadband (linear_deadband_reg),
        .result   (linear_res),
        .state    (linear_state)
    );

    vcs_lane #(
        .DATA_WIDTH  (DATA_WIDTH),
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_angular_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (lane_ctrl),
        .cmd      (angular_cmd),
        .coeff    (angular_coeff_reg),
        .limit    (angular_limit_reg),
        .deadband (angular_deadband_reg),
        .result   (angular_res),
        .state    (angular_state)
    );

    vcs_merge #(
        .DATA_WIDTH (DATA_WIDTH),
        .TDATA_W    (TDATA_W)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (in_fire),
        .linear_res    (linear_res),
        .angular_res   (angular_res),
        .ready         (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .skid_valid    (skid_valid)
    );

    // skid entry only fills behind an occupied output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid |-> m_axis_tvalid)
        else $error("skid entry valid with empty output register");

    // a clear transaction leaves both lane states at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tuser) |=> (linear_state == '0 && angular_state == '0))
        else $error("lane state not cleared");

    // a delivered linear speed never exceeds the configured limit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[DATA_WIDTH-1:0]) <= $signed({1'b0, linear_limit_reg}) &&
             $signed(m_axis_tdata[DATA_WIDTH-1:0]) >= -$signed({1'b0, linear_limit_reg})))
        else $error("linear output outside limit");

endmodule

[sim/vcs_smoother_checker.sv]
module vcs_smoother_checker
    import vcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // [15:0] linear_cmd, [31:16] angular_cmd
    input  logic [31:0]           s_axis_tdata,
    // [0] clear
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] linear_out, [31:16] angular_out
    input  logic [31:0]           m_axis_tdata,
    input  logic                  wr_en,
    input  logic [REG_ADDR_W-1:0] wr_addr,
    input  logic [15:0]           wr_data,
    output int                    fail_count,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC_BITS = 16;
    localparam longint COEFF_ONE = 64'sd1 << FRAC_BITS;

    typedef struct packed {
        logic signed [15:0] angular;
        logic signed [15:0] linear;
    } speed_pair_t;

    speed_pair_t        smoothed_q[$];
    logic [15:0]        lin_coeff;
    logic [15:0]        ang_coeff;
    logic [14:0]        lin_limit;
    logic [14:0]        lin_deadband;
    logic [14:0]        ang_limit;
    logic [14:0]        ang_deadband;
    logic signed [15:0] lin_state;
    logic signed [15:0] ang_state;

    initial fail_count = 0;
    initial outstanding = 0;

    // One smoothing step of a lane: blend, floor shift, deadband, clamp.
    function automatic logic signed [15:0] smooth_lane(
        input  logic signed [15:0] prev,
        input  logic signed [15:0] cmd,
        input  logic [15:0]        coeff,
        input  logic [14:0]        limit,
        input  logic [14:0]        deadband,
        output logic signed [15:0] next_state
    );
        longint acc;
        longint s;
        longint mag;
        acc = longint'(coeff) * longint'(prev)
            + (COEFF_ONE - longint'(coeff)) * longint'(cmd);
        s = acc >>> FRAC_BITS;
        mag = (s < 0) ? -s : s;
        // Inside the deadband: keep the unclamped state, output zero
        if (mag < longint'(deadband)) begin
            next_state = s[15:0];
            return '0;
        end
        if (s > longint'(limit))
            s = longint'(limit);
        else if (s < -longint'(limit))
            s = -longint'(limit);
        next_state = s[15:0];
        return s[15:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        speed_pair_t        got;
        speed_pair_t        want;
        speed_pair_t        next;
        logic signed [15:0] ns;
        int                 in_fire;
        int                 out_fire;
        if (!rst_n)
        begin
            lin_coeff    = '0;
            ang_coeff    = '0;
            lin_limit    = 15'(LINEAR_LIMIT_RST);
            lin_deadband = 15'(LINEAR_DEADBAND_RST);
            ang_limit    = 15'(ANGULAR_LIMIT_RST);
            ang_deadband = 15'(ANGULAR_DEADBAND_RST);
            lin_state    = '0;
            ang_state    = '0;
            smoothed_q.delete();
            outstanding <= 0;
        end
        else
        begin
            in_fire  = (s_axis_tvalid && s_axis_tready) ? 1 : 0;
            out_fire = (m_axis_tvalid && m_axis_tready) ? 1 : 0;

            if (out_fire != 0)
            begin
                got = m_axis_tdata;
                if (smoothed_q.size() == 0)
                    report_mismatch($sformatf("result with nothing pending: linear %0d angular %0d",
                                              got.linear, got.angular));
                else
                begin
                    want = smoothed_q.pop_front();
                    if (got.linear !== want.linear)
                        report_mismatch($sformatf("linear_out: got %0d, expected %0d",
                                                  got.linear, want.linear));
                    if (got.angular !== want.angular)
                        report_mismatch($sformatf("angular_out: got %0d, expected %0d",
                                                  got.angular, want.angular));
                end
            end

            if (in_fire != 0)
            begin
                if (s_axis_tuser)
                begin
                    lin_state = '0;
                    ang_state = '0;
                    next = '0;
                end
                else
                begin
                    next.linear = smooth_lane(lin_state, s_axis_tdata[15:0], lin_coeff,
                                              lin_limit, lin_deadband, ns);
                    lin_state = ns;
                    next.angular = smooth_lane(ang_state, s_axis_tdata[31:16], ang_coeff,
                                               ang_limit, ang_deadband, ns);
                    ang_state = ns;
                end
                smoothed_q.push_back(next);
            end

            outstanding <= outstanding + in_fire - out_fire;

            // New settings apply from the next transaction on
            if (wr_en)
            begin
                case (wr_addr)
                    REG_LINEAR_COEFF:     lin_coeff    = wr_data;
                    REG_ANGULAR_COEFF:    ang_coeff    = wr_data;
                    REG_LINEAR_LIMIT:     lin_limit    = wr_data[14:0];
                    REG_LINEAR_DEADBAND:  lin_deadband = wr_data[14:0];
                    REG_ANGULAR_LIMIT:    ang_limit    = wr_data[14:0];
                    REG_ANGULAR_DEADBAND: ang_deadband = wr_data[14:0];
                    default:              ;
                endcase
            end
        end
    end

endmodule

[sim/tb_velocity_command_smoother.sv]
module tb_velocity_command_smoother
    import vcs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASES       = 8;
    localparam int SETTLE       = 10;

    // Indexes beyond the register map; writes there must be ignored
    localparam logic [REG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [REG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic                  wr_en         = 1'b0;
    logic [REG_ADDR_W-1:0] wr_addr       = '0;
    logic [15:0]           wr_data       = '0;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    bit calm_tx     = 1'b0;

    velocity_command_smoother dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    vcs_smoother_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic signed [15:0] sat16(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_coeff();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3, 4:    return 16'($urandom_range(49152, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2, 3:    return 16'($urandom_range(2048, 8192));
            // Top bit is outside the register and must be dropped
            4:       return 16'($urandom);
            default: return 16'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic logic [15:0] pick_deadband();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'($urandom_range(0, 32767));
            2:       return 16'($urandom_range(4000, 9000));
            default: return 16'($urandom_range(1, 200));
        endcase
    endfunction

    function automatic int pick_speed();
        int mag;
        case ($urandom_range(0, 7))
            0:       return 32767;
            1:       return -32768;
            2:       mag = $urandom_range(0, 300);
            3, 4:    mag = $urandom_range(1000, 9000);
            default: return int'($signed(16'($urandom)));
        endcase
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    // Receiver: random stalls, with calm stretches of full throughput
    initial
    begin : sink
        int stall;
        int span;
        bit calm_rx;
        stall = 0;
        span = 0;
        calm_rx = 1'b0;
        forever
        begin
            @(posedge clk);
            span++;
            if (span % 256 == 0)
                calm_rx = ($urandom_range(0, 3) == 0);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!calm_rx)
                    stall = pick_gap();
            end
        end
    end

    // Hold the command until accepted, then maybe leave a gap
    task automatic send_speed(input logic signed [15:0] lin, input logic signed [15:0] ang,
                              input logic clr);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ang, lin};
        s_axis_tuser  <= clr;
        do
            @(posedge clk);
        while (!s_axis_tready);
        gap = calm_tx ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Leaves wr_en high; the caller lowers it after the last write
    task automatic write_reg(input logic [REG_ADDR_W-1:0] addr, input logic [15:0] data);
        wr_en   <= 1'b1;
        wr_addr <= addr;
        wr_data <= data;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [15:0] lc, input logic [15:0] ac,
                               input logic [15:0] ll, input logic [15:0] ld,
                               input logic [15:0] al, input logic [15:0] ad);
        write_reg(REG_LINEAR_COEFF, lc);
        write_reg(REG_ANGULAR_COEFF, ac);
        write_reg(REG_LINEAR_LIMIT, ll);
        write_reg(REG_LINEAR_DEADBAND, ld);
        write_reg(REG_ANGULAR_LIMIT, al);
        write_reg(REG_ANGULAR_DEADBAND, ad);
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
        wr_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        int ph;
        int sent;
        int run_len;
        int lin_target;
        int ang_target;
        logic clr;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero coefficient, state follows the clamped command
        send_speed(16'sd0, 16'sd0, 1'b0);
        send_speed(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_speed(16'sh8000, 16'sh8000, 1'b0);
        send_speed(16'sd40, 16'sd81, 1'b0);
        send_speed(-16'sd41, -16'sd82, 1'b0);
        send_speed(16'sd41, 16'sd82, 1'b0);
        send_speed(16'sd4096, 16'sd6434, 1'b0);
        send_speed(16'sd4097, 16'sd6435, 1'b0);
        send_speed(-16'sd4097, -16'sd6435, 1'b0);
        send_speed(16'sd1, -16'sd1, 1'b0);
        send_speed(16'($urandom), 16'($urandom), 1'b1);
        drain();

        // Heaviest smoothing, deadband above a zero limit
        load_config(16'hFFFF, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF);
        send_speed(16'sh7FFF, 16'sh8000, 1'b0);
        send_speed(16'sh8000, 16'sh7FFF, 1'b0);
        send_speed(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_speed(16'($urandom), 16'($urandom), 1'b1);
        drain();

        // Half weight on linear, widest limits, no deadband
        load_config(16'h8000, 16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000);
        send_speed(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_speed(16'sh7FFF, 16'sh8000, 1'b0);
        send_speed(16'sh8000, 16'sh8000, 1'b0);
        send_speed(16'sh8000, 16'sd0, 1'b0);
        send_speed(16'sd0, 16'sd0, 1'b0);

        for (ph = 0; ph < PHASES; ph++)
        begin
            drain();
            if (ph == 0)
                load_config(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000);
            else if (ph == 1)
                load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
            else
                load_config(pick_coeff(), pick_coeff(), pick_limit(), pick_deadband(),
                            pick_limit(), pick_deadband());
            calm_tx = (ph % 3 == 2);
            sent = 0;
            // Hold a target for a while so the states settle and hit the limits
            while (sent < RANDOM_ITEMS / PHASES)
            begin
                run_len = $urandom_range(1, 24);
                lin_target = pick_speed();
                ang_target = pick_speed();
                repeat (run_len)
                begin
                    clr = ($urandom_range(0, 49) == 0);
                    send_speed(sat16(lin_target + $urandom_range(0, 128) - 64),
                               sat16(ang_target + $urandom_range(0, 128) - 64), clr);
                    sent++;
                end
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
hw/rtl/vcs_pkg.sv
hw/rtl/vcs_lane.sv
hw/rtl/vcs_merge.sv
hw/rtl/velocity_command_smoother.sv
sim/vcs_smoother_checker.sv
sim/tb_velocity_command_smoother.sv
